@@ src/hrlp_pkg.sv @@
// ----------------------------------------------------------------------------
// hrlp_pkg
// Shared constants, method name table and result type for the HTTP request
// line parser.
// ----------------------------------------------------------------------------
package hrlp_pkg;

    // Method letter store
    localparam int MAX_METHOD_LEN = 7;
    localparam int METHOD_W       = 8 * MAX_METHOD_LEN;
    localparam int LEN_W          = $clog2(MAX_METHOD_LEN + 2);
    localparam int NUM_METHODS    = 8;

    // Status codes
    localparam logic [1:0] STATUS_PROGRESS = 2'd0;
    localparam logic [1:0] STATUS_OK       = 2'd1;
    localparam logic [1:0] STATUS_INVALID  = 2'd2;

    // Method codes
    localparam logic [3:0] METHOD_GET     = 4'd0;
    localparam logic [3:0] METHOD_UNKNOWN = 4'd8;

    // Known method names, first letter in the low byte, zero padded
    localparam logic [63:0] METHOD_NAME [NUM_METHODS] = '{
        64'h0000_0000_0054_4547,   // GET
        64'h0000_0000_5453_4f50,   // POST
        64'h0000_0048_4354_4150,   // PATCH
        64'h0000_0000_0054_5550,   // PUT
        64'h0000_4554_454c_4544,   // DELETE
        64'h0054_4345_4e4e_4f43,   // CONNECT
        64'h0053_4e4f_4954_504f,   // OPTIONS
        64'h0000_0045_4341_5254    // TRACE
    };
    localparam int METHOD_LEN [NUM_METHODS] = '{3, 4, 5, 3, 6, 7, 7, 5};

    // Character codes
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_SLASH = 8'h2f;
    localparam logic [7:0] CH_DOT   = 8'h2e;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_H     = 8'h48;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_UPPER_LO = 8'h41;
    localparam logic [7:0] CH_UPPER_HI = 8'h5a;
    localparam logic [7:0] CH_DIGIT_LO = 8'h30;
    localparam logic [7:0] CH_DIGIT_HI = 8'h39;

    // One result item
    typedef struct packed {
        logic [1:0] status;
        logic [3:0] method_code;
        logic [3:0] major_version;
        logic [3:0] minor_version;
        logic       resource_valid;
        logic [7:0] resource_byte;
    } hrlp_result_t;

endpackage

@@ src/hrlp_method_class.sv @@
// ----------------------------------------------------------------------------
// hrlp_method_class
// Matches the collected method letters against the known method names.
// ----------------------------------------------------------------------------
module hrlp_method_class (
    input  logic [hrlp_pkg::METHOD_W-1:0] method_chars,
    input  logic [hrlp_pkg::LEN_W-1:0]    method_len,
    output logic [3:0]                    method_code
);
    import hrlp_pkg::*;

    // Compare length and padded letters; unused bytes are always zero
    always_comb
    begin
        method_code = METHOD_UNKNOWN;
        for (int k = NUM_METHODS - 1; k >= 0; k--)
        begin
            if (METHOD_LEN[k] <= MAX_METHOD_LEN &&
                method_len == LEN_W'(METHOD_LEN[k]) &&
                method_chars == METHOD_NAME[k][METHOD_W-1:0])
            begin
                method_code = 4'(k);
            end
        end
    end

endmodule

@@ src/hrlp_fsm.sv @@
// ----------------------------------------------------------------------------
// hrlp_fsm
// Character state machine: parser state, method letters, version digits and
// outcome, updated once for each accepted byte.
// ----------------------------------------------------------------------------
module hrlp_fsm (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  accept,
    input  logic [7:0]            ch,
    input  logic                  first,
    input  logic                  last,
    output hrlp_pkg::hrlp_result_t result
);
    import hrlp_pkg::*;

    typedef enum logic [13:0] {
        S_START          = 14'h0001,
        S_LETTERS        = 14'h0002,
        S_SP_BEFORE_RES  = 14'h0004,
        S_PATH           = 14'h0008,
        S_SP_AFTER_RES   = 14'h0010,
        S_H              = 14'h0020,
        S_HT             = 14'h0040,
        S_HTT            = 14'h0080,
        S_HTTP           = 14'h0100,
        S_MAJOR          = 14'h0200,
        S_MAJOR_SEEN     = 14'h0400,
        S_MINOR          = 14'h0800,
        S_SP_AFTER_VER   = 14'h1000,
        S_CR_SEEN        = 14'h2000
    } parse_state_t;

    parse_state_t          state_reg, state_next, state_eff;
    logic [METHOD_W-1:0]   chars_reg, chars_next, chars_eff;
    logic [LEN_W-1:0]      len_reg, len_next, len_eff;
    logic [3:0]            class_reg, class_next, class_eff;
    logic [3:0]            major_reg, major_next, major_eff;
    logic [3:0]            minor_reg, minor_next, minor_eff;
    logic [1:0]            outcome_reg, outcome_next, outcome_eff;
    logic [3:0]            class_found;
    logic                  is_upper, is_digit;
    logic                  bad, done, res_valid;

    // Classify the letters held so far
    hrlp_method_class u_class (
        .method_chars (chars_reg),
        .method_len   (len_reg),
        .method_code  (class_found)
    );

    assign is_upper = (ch >= CH_UPPER_LO) && (ch <= CH_UPPER_HI);
    assign is_digit = (ch >= CH_DIGIT_LO) && (ch <= CH_DIGIT_HI);

    // Drop held state when a new line starts
    always_comb
    begin
        if (first)
        begin
            state_eff   = S_START;
            chars_eff   = '0;
            len_eff     = '0;
            class_eff   = METHOD_UNKNOWN;
            major_eff   = '0;
            minor_eff   = '0;
            outcome_eff = STATUS_PROGRESS;
        end
        else
        begin
            state_eff   = state_reg;
            chars_eff   = chars_reg;
            len_eff     = len_reg;
            class_eff   = class_reg;
            major_eff   = major_reg;
            minor_eff   = minor_reg;
            outcome_eff = outcome_reg;
        end
    end

    // Advance the state machine by one byte
    always_comb
    begin
        state_next   = state_eff;
        chars_next   = chars_eff;
        len_next     = len_eff;
        class_next   = class_eff;
        major_next   = major_eff;
        minor_next   = minor_eff;
        outcome_next = outcome_eff;
        bad          = 1'b0;
        done         = 1'b0;
        res_valid    = 1'b0;

        if (outcome_eff == STATUS_PROGRESS)
        begin
            unique case (state_eff)
                S_START, S_LETTERS:
                begin
                    if (state_eff == S_LETTERS && ch == CH_SPACE)
                    begin
                        class_next = class_found;
                        state_next = S_SP_BEFORE_RES;
                    end
                    else if (!is_upper)
                    begin
                        bad = 1'b1;
                    end
                    else
                    begin
                        state_next = S_LETTERS;
                        if (len_eff < LEN_W'(MAX_METHOD_LEN))
                        begin
                            for (int i = 0; i < MAX_METHOD_LEN; i++)
                            begin
                                if (len_eff == LEN_W'(i))
                                    chars_next[8*i +: 8] = ch;
                            end
                            len_next = len_eff + LEN_W'(1);
                        end
                        else
                        begin
                            // mark the method as overlong
                            len_next = LEN_W'(MAX_METHOD_LEN + 1);
                        end
                    end
                end
                S_SP_BEFORE_RES:
                begin
                    if (ch != CH_SLASH)
                        bad = 1'b1;
                    else
                    begin
                        res_valid  = 1'b1;
                        state_next = S_PATH;
                    end
                end
                S_PATH:
                begin
                    if (ch == CH_SPACE)
                        state_next = S_SP_AFTER_RES;
                    else
                        res_valid = 1'b1;
                end
                S_SP_AFTER_RES:
                begin
                    if (ch == CH_H) state_next = S_H; else bad = 1'b1;
                end
                S_H:
                begin
                    if (ch == CH_T) state_next = S_HT; else bad = 1'b1;
                end
                S_HT:
                begin
                    if (ch == CH_T) state_next = S_HTT; else bad = 1'b1;
                end
                S_HTT:
                begin
                    if (ch == CH_P) state_next = S_HTTP; else bad = 1'b1;
                end
                S_HTTP:
                begin
                    if (ch == CH_SLASH) state_next = S_MAJOR; else bad = 1'b1;
                end
                S_MAJOR:
                begin
                    if (!is_digit)
                        bad = 1'b1;
                    else
                    begin
                        major_next = ch[3:0];
                        state_next = S_MAJOR_SEEN;
                    end
                end
                S_MAJOR_SEEN:
                begin
                    if (ch == CH_SPACE)      state_next = S_SP_AFTER_VER;
                    else if (ch == CH_LF)    done = 1'b1;
                    else if (ch == CH_CR)    state_next = S_CR_SEEN;
                    else if (ch == CH_DOT)   state_next = S_MINOR;
                    else                     bad = 1'b1;
                end
                S_MINOR:
                begin
                    if (ch == CH_SPACE)      state_next = S_SP_AFTER_VER;
                    else if (ch == CH_CR)    state_next = S_CR_SEEN;
                    else if (ch == CH_LF)    done = 1'b1;
                    else if (is_digit)       minor_next = ch[3:0];
                    else                     bad = 1'b1;
                end
                S_SP_AFTER_VER:
                begin
                    if (ch == CH_LF)         done = 1'b1;
                    else if (ch != CH_SPACE) bad = 1'b1;
                end
                S_CR_SEEN:
                begin
                    if (ch == CH_LF) done = 1'b1; else bad = 1'b1;
                end
                default:
                begin
                    bad = 1'b1;
                end
            endcase

            if (bad)
            begin
                outcome_next = STATUS_INVALID;
                res_valid    = 1'b0;
            end
            else if (done || last)
            begin
                outcome_next = STATUS_OK;
            end
        end
    end

    // Build the result for this byte
    always_comb
    begin
        result.status         = outcome_next;
        result.method_code    = class_next;
        result.major_version  = major_next;
        result.minor_version  = minor_next;
        result.resource_valid = res_valid;
        result.resource_byte  = res_valid ? ch : 8'h00;
    end

    // Hold state between transfers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_START;
            chars_reg   <= '0;
            len_reg     <= '0;
            class_reg   <= METHOD_UNKNOWN;
            major_reg   <= '0;
            minor_reg   <= '0;
            outcome_reg <= STATUS_PROGRESS;
        end
        else if (accept)
        begin
            state_reg   <= state_next;
            chars_reg   <= chars_next;
            len_reg     <= len_next;
            class_reg   <= class_next;
            major_reg   <= major_next;
            minor_reg   <= minor_next;
            outcome_reg <= outcome_next;
        end
    end

`ifndef NO_ASSERTIONS
    // A final result freezes the parser until a new line starts
    a_final_holds: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !first && outcome_reg != STATUS_PROGRESS
        |=> $stable(outcome_reg) && $stable(state_reg) && $stable(class_reg))
        else $error("parser state moved after a final result");

    // A resource byte is never reported with an invalid status
    a_res_progress: assert property (@(posedge clk) disable iff (!rst_n)
        result.resource_valid |-> result.status != STATUS_INVALID)
        else $error("resource byte with an invalid status");

    // A new line holds at most one method letter after its first byte
    a_first_len: assert property (@(posedge clk) disable iff (!rst_n)
        accept && first |=> len_reg <= LEN_W'(1))
        else $error("method letters survived a new line");

    // The method is classified only after leaving the method letters
    a_class_late: assert property (@(posedge clk) disable iff (!rst_n)
        class_reg != METHOD_UNKNOWN |-> state_reg != S_START && state_reg != S_LETTERS)
        else $error("method classified too early");
`endif

endmodule

@@ src/hrlp_out_stage.sv @@
// ----------------------------------------------------------------------------
// hrlp_out_stage
// Result register with valid/ready handshake; takes a new result in the same
// cycle the held one transfers.
// ----------------------------------------------------------------------------
module hrlp_out_stage (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   req_valid,
    output logic                   req_ready,
    input  hrlp_pkg::hrlp_result_t result_in,
    output logic                   res_valid,
    input  logic                   res_ready,
    output hrlp_pkg::hrlp_result_t result_out
);
    import hrlp_pkg::*;

    logic         valid_reg;
    hrlp_result_t data_reg;

    // Accept while empty or while the held result leaves
    assign req_ready = !valid_reg || res_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (req_ready)
            valid_reg <= req_valid;
    end

    // Load the payload on every input transfer
    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
            data_reg <= result_in;
    end

    assign res_valid  = valid_reg;
    assign result_out = data_reg;

endmodule

@@ src/http_request_line_parser_core.sv @@
// ----------------------------------------------------------------------------
// http_request_line_parser_core
// HTTP request line parser: one byte in, one status result out per byte.
// ----------------------------------------------------------------------------
//  channel | handshake             | payload
//  --------+-----------------------+-----------------------------------------
//  request | req_valid / req_ready | ch, first, last
//  result  | res_valid / res_ready | status, method_code, major_version,
//          |                       | minor_version, resource_valid,
//          |                       | resource_byte
//
// One byte per cycle while the result register can take it; each result is
// registered there and appears in the cycle after its byte transfers.
// Reset puts the parser in its start state with an empty result register.
// A stalled result holds in the result register; a new byte is taken in the
// same cycle the held result transfers.
// ----------------------------------------------------------------------------
module http_request_line_parser_core (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_ready,
    input  logic [7:0] ch,
    input  logic       first,
    input  logic       last,
    output logic       res_valid,
    input  logic       res_ready,
    output logic [1:0] status,
    output logic [3:0] method_code,
    output logic [3:0] major_version,
    output logic [3:0] minor_version,
    output logic       resource_valid,
    output logic [7:0] resource_byte
);
    import hrlp_pkg::*;

    hrlp_result_t result_d, result_q;
    logic         accept;

    assign accept = req_valid && req_ready;

    // Parse one byte per transfer
    hrlp_fsm u_fsm (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .ch     (ch),
        .first  (first),
        .last   (last),
        .result (result_d)
    );

    // Register the result toward the consumer
    hrlp_out_stage u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .result_in  (result_d),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .result_out (result_q)
    );

    assign status         = result_q.status;
    assign method_code    = result_q.method_code;
    assign major_version  = result_q.major_version;
    assign minor_version  = result_q.minor_version;
    assign resource_valid = result_q.resource_valid;
    assign resource_byte  = result_q.resource_byte;

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for http_request_line_parser_core. A queue of
// request line bytes (a few hand-picked lines, then mostly well-formed random
// lines mixed with corrupted, truncated and noise lines) feeds a valid/ready
// driver. Each byte transfer runs a line parser model that queues the
// expected result. The monitor checks every result transfer against it.
// Both channels idle at random in the first two of three phases only.
// ----------------------------------------------------------------------------
module tb_top;
    import hrlp_pkg::*;

    localparam int LIMIT_CYCLES = 200000;
    localparam int RANDOM_BYTES = 1700;
    localparam int DRAIN_CYCLES = 10;

    typedef enum logic [3:0] {
        LN_START,
        LN_METHOD,
        LN_SP_BEFORE_RES,
        LN_RESOURCE,
        LN_SP_AFTER_RES,
        LN_H,
        LN_HT,
        LN_HTT,
        LN_HTTP,
        LN_MAJOR,
        LN_AFTER_MAJOR,
        LN_MINOR,
        LN_SP_AFTER_VER,
        LN_ALMOST_DONE
    } line_state_e;

    typedef struct packed {
        logic [7:0] ch;
        logic       first;
        logic       last;
    } line_byte_t;

    // Method names indexed by method code, last letter in the low byte
    localparam logic [METHOD_W-1:0] KNOWN_NAME [NUM_METHODS] = '{
        "GET", "POST", "PATCH", "PUT", "DELETE", "CONNECT", "OPTIONS", "TRACE"
    };

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       req_valid = 1'b0;
    logic       req_ready;
    logic [7:0] ch = 8'h00;
    logic       first = 1'b0;
    logic       last = 1'b0;
    logic       res_valid;
    logic       res_ready = 1'b0;
    logic [1:0] status;
    logic [3:0] method_code;
    logic [3:0] major_version;
    logic [3:0] minor_version;
    logic       resource_valid;
    logic [7:0] resource_byte;

    line_byte_t   byte_q [$];
    logic [7:0]   line_buf [$];
    hrlp_result_t line_results_q [$];

    logic req_took = 1'b0;
    int   cycle_cnt = 0;
    int   accepted_cnt = 0;
    int   total_bytes = 0;
    int   fail_cnt = 0;

    // Line parser model state
    line_state_e         line_state = LN_START;
    logic [METHOD_W-1:0] name_acc = '0;
    int                  name_len = 0;
    logic [3:0]          method_sel = METHOD_UNKNOWN;
    logic [3:0]          major_sel = 4'd0;
    logic [3:0]          minor_sel = 4'd0;
    logic [1:0]          line_status = STATUS_PROGRESS;

    http_request_line_parser_core u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_valid      (req_valid),
        .req_ready      (req_ready),
        .ch             (ch),
        .first          (first),
        .last           (last),
        .res_valid      (res_valid),
        .res_ready      (res_ready),
        .status         (status),
        .method_code    (method_code),
        .major_version  (major_version),
        .minor_version  (minor_version),
        .resource_valid (resource_valid),
        .resource_byte  (resource_byte)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // Match the collected letters against the known names
    function automatic logic [3:0] classify_name();
        logic [3:0] code;
        code = METHOD_UNKNOWN;
        if (name_len <= MAX_METHOD_LEN)
            for (int k = 0; k < NUM_METHODS; k++)
                if (name_acc == KNOWN_NAME[k])
                    code = 4'(k);
        return code;
    endfunction

    function automatic logic is_upper(input logic [7:0] c);
        return c >= CH_UPPER_LO && c <= CH_UPPER_HI;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= CH_DIGIT_LO && c <= CH_DIGIT_HI;
    endfunction

    // Advance the line model by one byte and return the result it gives
    function automatic hrlp_result_t parse_step(input logic [7:0] c, input logic f,
                                                input logic l);
        hrlp_result_t r;
        logic         bad;
        logic         done;
        logic         take;
        bad  = 1'b0;
        done = 1'b0;
        take = 1'b0;
        if (f)
        begin
            line_state  = LN_START;
            name_acc    = '0;
            name_len    = 0;
            method_sel  = METHOD_UNKNOWN;
            major_sel   = 4'd0;
            minor_sel   = 4'd0;
            line_status = STATUS_PROGRESS;
        end
        if (line_status == STATUS_PROGRESS)
        begin
            case (line_state)
                LN_START, LN_METHOD:
                    if (line_state == LN_METHOD && c == CH_SPACE)
                    begin
                        method_sel = classify_name();
                        line_state = LN_SP_BEFORE_RES;
                    end
                    else if (is_upper(c))
                    begin
                        // keep letters up to the store size, then mark overlong
                        if (name_len < MAX_METHOD_LEN)
                        begin
                            name_acc = {name_acc[METHOD_W-9:0], c};
                            name_len++;
                        end
                        else
                            name_len = MAX_METHOD_LEN + 1;
                        line_state = LN_METHOD;
                    end
                    else
                        bad = 1'b1;
                LN_SP_BEFORE_RES:
                    if (c == CH_SLASH)
                    begin
                        take = 1'b1;
                        line_state = LN_RESOURCE;
                    end
                    else
                        bad = 1'b1;
                LN_RESOURCE:
                    if (c == CH_SPACE)
                        line_state = LN_SP_AFTER_RES;
                    else
                        take = 1'b1;
                LN_SP_AFTER_RES:
                    if (c == CH_H) line_state = LN_H; else bad = 1'b1;
                LN_H:
                    if (c == CH_T) line_state = LN_HT; else bad = 1'b1;
                LN_HT:
                    if (c == CH_T) line_state = LN_HTT; else bad = 1'b1;
                LN_HTT:
                    if (c == CH_P) line_state = LN_HTTP; else bad = 1'b1;
                LN_HTTP:
                    if (c == CH_SLASH) line_state = LN_MAJOR; else bad = 1'b1;
                LN_MAJOR:
                    if (is_digit(c))
                    begin
                        major_sel  = 4'(c - CH_DIGIT_LO);
                        line_state = LN_AFTER_MAJOR;
                    end
                    else
                        bad = 1'b1;
                LN_AFTER_MAJOR:
                    if (c == CH_SPACE) line_state = LN_SP_AFTER_VER;
                    else if (c == CH_LF) done = 1'b1;
                    else if (c == CH_CR) line_state = LN_ALMOST_DONE;
                    else if (c == CH_DOT) line_state = LN_MINOR;
                    else bad = 1'b1;
                LN_MINOR:
                    if (c == CH_SPACE) line_state = LN_SP_AFTER_VER;
                    else if (c == CH_CR) line_state = LN_ALMOST_DONE;
                    else if (c == CH_LF) done = 1'b1;
                    else if (is_digit(c)) minor_sel = 4'(c - CH_DIGIT_LO);
                    else bad = 1'b1;
                LN_SP_AFTER_VER:
                    if (c == CH_LF) done = 1'b1;
                    else if (c != CH_SPACE) bad = 1'b1;
                LN_ALMOST_DONE:
                    if (c == CH_LF) done = 1'b1; else bad = 1'b1;
                default:
                    bad = 1'b1;
            endcase
            if (bad)
            begin
                line_status = STATUS_INVALID;
                take = 1'b0;
            end
            else if (done || l)
                line_status = STATUS_OK;
        end
        r.status         = line_status;
        r.method_code    = method_sel;
        r.major_version  = major_sel;
        r.minor_version  = minor_sel;
        r.resource_valid = take;
        r.resource_byte  = take ? c : 8'h00;
        return r;
    endfunction

    task automatic check_field(input string fname, input logic [7:0] want,
                               input logic [7:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, fname, want, got);
            fail_cnt++;
        end
    endtask

    task automatic push_item(input logic [7:0] c, input logic f, input logic l);
        line_byte_t item;
        item.ch    = c;
        item.first = f;
        item.last  = l;
        byte_q.insert(byte_q.size(), item);
    endtask

    // Append one byte to the line buffer
    task automatic add_byte(input logic [7:0] b);
        line_buf.insert(line_buf.size(), b);
    endtask

    // Append the nonzero bytes of a packed text, first letter first
    task automatic add_text(input logic [METHOD_W-1:0] txt);
        for (int i = METHOD_W / 8 - 1; i >= 0; i--)
            if (txt[8*i +: 8] != 8'h00)
                add_byte(txt[8*i +: 8]);
    endtask

    // Queue the first count bytes of the line buffer, then clear it
    task automatic emit_line(input int count, input logic end_mark);
        for (int i = 0; i < count; i++)
            push_item(line_buf[i], i == 0, end_mark && i == count - 1);
        line_buf.delete();
    endtask

    // Build one well-formed request line with random content
    task automatic build_request();
        int         n;
        int         pick;
        logic [7:0] b;
        if ($urandom_range(99) < 80)
            add_text(KNOWN_NAME[$urandom_range(NUM_METHODS - 1)]);
        else
        begin
            n = $urandom_range(10, 1);
            repeat (n) add_byte(8'($urandom_range(CH_UPPER_HI, CH_UPPER_LO)));
        end
        add_byte(CH_SPACE);
        add_byte(CH_SLASH);
        n = $urandom_range(6);
        repeat (n)
        begin
            b = 8'($urandom_range(255));
            add_byte(b == CH_SPACE ? CH_SLASH : b);
        end
        add_text(" HTTP/");
        add_byte(8'($urandom_range(CH_DIGIT_HI, CH_DIGIT_LO)));
        if ($urandom_range(99) < 60)
        begin
            add_byte(CH_DOT);
            n = $urandom_range(2);
            repeat (n) add_byte(8'($urandom_range(CH_DIGIT_HI, CH_DIGIT_LO)));
        end
        if ($urandom_range(99) < 30)
        begin
            n = $urandom_range(2, 1);
            repeat (n) add_byte(CH_SPACE);
        end
        pick = $urandom_range(9);
        if (pick < 5)
        begin
            add_byte(CH_CR);
            add_byte(CH_LF);
        end
        else if (pick < 8)
            add_byte(CH_LF);
    endtask

    // Drive request bytes and result ready at the falling edge
    always @(negedge clk)
    begin : drive_bytes
        int         send_idle;
        int         recv_idle;
        line_byte_t item;
        if (accepted_cnt < total_bytes / 3)
        begin
            send_idle = 28;
            recv_idle = 58;
        end
        else if (accepted_cnt < 2 * total_bytes / 3)
        begin
            send_idle = 58;
            recv_idle = 28;
        end
        else
        begin
            send_idle = 0;
            recv_idle = 0;
        end
        if (!rst_n)
            req_valid <= 1'b0;
        else if (!req_valid || req_took)
        begin
            if (byte_q.size() != 0 && $urandom_range(99) >= send_idle)
            begin
                item = byte_q.pop_front();
                req_valid <= 1'b1;
                ch        <= item.ch;
                first     <= item.first;
                last      <= item.last;
            end
            else
                req_valid <= 1'b0;
        end
        res_ready <= ($urandom_range(99) >= recv_idle);
    end

    // Check result transfers, then predict for the byte transfer
    always @(posedge clk)
    begin : watch_results
        hrlp_result_t want;
        cycle_cnt <= cycle_cnt + 1;
        req_took  <= rst_n && req_valid && req_ready;
        if (rst_n && res_valid && res_ready)
        begin
            if (line_results_q.size() == 0)
            begin
                $display("%0t: result with none expected, expected none actual status %0h",
                         $time, status);
                fail_cnt++;
            end
            else
            begin
                want = line_results_q.pop_front();
                check_field("status", want.status, status);
                check_field("method_code", want.method_code, method_code);
                check_field("major_version", want.major_version, major_version);
                check_field("minor_version", want.minor_version, minor_version);
                check_field("resource_valid", want.resource_valid, resource_valid);
                check_field("resource_byte", want.resource_byte, resource_byte);
            end
        end
        if (rst_n && req_valid && req_ready)
        begin
            line_results_q.insert(line_results_q.size(), parse_step(ch, first, last));
            accepted_cnt <= accepted_cnt + 1;
        end
    end

    initial
    begin : run_test
        int   random_cnt;
        int   kind;
        int   n;
        int   keep;
        logic end_mark;
        logic timed_out;
        random_cnt = 0;

        // Lone letter closed by the last mark: no space, method stays unknown
        add_byte("A");
        emit_line(1, 1'b1);
        // Zero byte as first byte is invalid; the next byte is ignored
        push_item(8'h00, 1'b1, 1'b0);
        push_item(8'hff, 1'b0, 1'b0);
        // Invalid byte with the last mark stays invalid
        push_item(8'hff, 1'b1, 1'b1);
        // Eight letters overflow the method store
        add_text("ABCDEFG");
        add_byte("H");
        add_byte(CH_SPACE);
        emit_line(9, 1'b1);
        // Control and high bytes in the resource, minor with no digits, bare LF
        add_text("PUT /");
        add_byte(8'h00);
        add_byte(8'hff);
        add_text(" HTTP/");
        add_text("9.");
        add_byte(CH_LF);
        emit_line(line_buf.size(), 1'b0);
        push_item("X", 1'b0, 1'b0);
        // Full line with CR LF and a two-digit minor
        add_text("GET /a ");
        add_text("HTTP/0.");
        add_text("12");
        add_byte(CH_CR);
        add_byte(CH_LF);
        emit_line(line_buf.size(), 1'b0);

        // Random lines: mostly well-formed, some corrupted, cut or noise
        while (random_cnt < RANDOM_BYTES)
        begin
            kind = $urandom_range(99);
            if (kind < 15)
            begin
                n = $urandom_range(6, 1);
                for (int i = 0; i < n; i++)
                    push_item(8'($urandom()), i == 0 || $urandom_range(9) == 0,
                              $urandom_range(4) == 0);
                random_cnt += n;
            end
            else
            begin
                build_request();
                keep = line_buf.size();
                if (kind < 30)
                begin
                    // corrupt one byte and drop most of the tail
                    n = $urandom_range(line_buf.size() - 1);
                    line_buf[n] = 8'($urandom());
                    if (keep > n + 3)
                        keep = n + 3;
                end
                else if (kind < 40)
                    keep = $urandom_range(line_buf.size() - 1, 1);
                if (line_buf[keep - 1] == CH_LF)
                    end_mark = ($urandom_range(9) == 0);
                else
                    end_mark = ($urandom_range(3) != 0);
                emit_line(keep, end_mark);
                random_cnt += keep;
                if ($urandom_range(9) == 0)
                    push_item(8'($urandom()), 1'b0, 1'b0);
            end
        end
        total_bytes = byte_q.size();

        // Hold reset, then release it at a falling edge
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while ((byte_q.size() != 0 || req_valid || line_results_q.size() != 0)
               && cycle_cnt < LIMIT_CYCLES)
            @(posedge clk);
        timed_out = (cycle_cnt >= LIMIT_CYCLES);
        if (!timed_out)
            repeat (DRAIN_CYCLES) @(posedge clk);

        if (timed_out)
            $display("status: fail");
        else if (fail_cnt == 0 && line_results_q.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

@@ sim.f @@
src/hrlp_pkg.sv
src/hrlp_method_class.sv
src/hrlp_fsm.sv
src/hrlp_out_stage.sv
src/http_request_line_parser_core.sv
sim/tb_top.sv
